FILE: rtl/actp_pkg.sv
// ----------------------------------------------------------------------------
// actp_pkg
// shared types and constants for the ascii command and time parser
// ----------------------------------------------------------------------------
package actp_pkg;

  // command classes, as reported in the result transaction
  typedef enum logic [2:0] {
    KindUnknown = 3'd0,
    KindPing    = 3'd1,
    KindOta     = 3'd2,
    KindVersion = 3'd3,
    KindSend    = 3'd4,
    KindSetTime = 3'd5,
    KindEnvOn   = 3'd6,
    KindEnvOff  = 3'd7
  } cmd_kind_e;

  localparam int unsigned NumPatterns = 7;
  localparam int unsigned MaxTextLen  = 11;
  localparam int unsigned TextW       = 8 * MaxTextLen;
  localparam int unsigned TimePattern = 4;   // index of the set-time prefix
  localparam int unsigned InW         = 8;
  localparam int unsigned OutW        = 56;  // 53 field bits, padded to bytes

  localparam logic [4:0] TimeTextLen = 5'd24;
  localparam logic [4:0] CountMax    = 5'd25;

  // vendor prefix shared by most commands, four characters
  localparam logic [31:0] CmdPrefix = {8'h4C, 8'h46, 8'h43, 8'h2B};

  // pattern text, right aligned, first character in the highest used byte
  function automatic logic [TextW-1:0] pat_str(input logic [2:0] idx);
    logic [TextW-1:0] s;
    case (idx)
      3'd0:    s = {56'd0, "PING"};
      3'd1:    s = {32'd0, CmdPrefix, "OTA"};
      3'd2:    s = {CmdPrefix, "VERSION"};
      3'd3:    s = {24'd0, CmdPrefix, "SEND"};
      3'd4:    s = {48'd0, "TIME="};
      3'd5:    s = {8'd0, CmdPrefix, "ENV=ON"};
      3'd6:    s = {CmdPrefix, "ENV=OFF"};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] pat_len(input logic [2:0] idx);
    logic [4:0] n;
    case (idx)
      3'd0:    n = 5'd4;
      3'd1:    n = 5'd7;
      3'd2:    n = 5'd11;
      3'd3:    n = 5'd8;
      3'd4:    n = 5'd5;
      3'd5:    n = 5'd10;
      3'd6:    n = 5'd11;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // character at position pos, valid only for pos below the pattern length
  function automatic logic [7:0] pat_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [TextW-1:0] sh;
    logic [3:0]       top;
    top = 4'(pat_len(idx) - 5'd1) - pos;
    sh  = pat_str(idx) >> {top, 3'b000};
    return sh[7:0];
  endfunction

endpackage

FILE: rtl/ascii_command_and_time_parser.sv
// ----------------------------------------------------------------------------
// ascii_command_and_time_parser
// byte-serial command classifier with set-time text decoding
// ----------------------------------------------------------------------------
// Takes one payload byte per clock while ready (tlast on the final byte)
// and, for every payload, returns one result transaction on the master
// stream: the command class, and for a well-formed 24-byte
// "TIME=YYYY-MM-DD,HH:MM:SS" payload the decoded year, month, day, hour,
// minute and second with time_ok set (all fields read zero otherwise; the
// calendar is not checked). Fixed commands must match in length and text;
// any payload of five or more bytes that starts with "TIME=" is set-time.
// Throughput is one byte per cycle while s_axis_tready_o is high: each
// byte passes through a single level of compare and multiply-by-ten logic
// into the running match and accumulator registers. The result is
// registered as the last byte is taken, into the output register, or into
// the skid register when the output register is full and stalled, so input
// only stalls once two finished results are waiting.
// After reset the block is ready at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ascii_command_and_time_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [actp_pkg::InW-1:0]  s_axis_tdata_i,   // [7:0] payload_byte
  input  logic                      s_axis_tlast_i,   // last_byte
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [2:0] command_kind, [3] time_ok, [17:4] year_out, [24:18] month_out,
  // [31:25] day_out, [38:32] hour_out, [45:39] minute_out,
  // [52:46] second_out, [55:53] zero
  output logic [actp_pkg::OutW-1:0] m_axis_tdata_o
);
  import actp_pkg::*;

  // positions of the separators inside the time text
  localparam logic [4:0] PosDash0  = 5'd9;
  localparam logic [4:0] PosDash1  = 5'd12;
  localparam logic [4:0] PosComma  = 5'd15;
  localparam logic [4:0] PosColon0 = 5'd18;
  localparam logic [4:0] PosColon1 = 5'd21;
  // last position of each digit group
  localparam logic [4:0] EndYear   = 5'd8;
  localparam logic [4:0] EndMonth  = 5'd11;
  localparam logic [4:0] EndDay    = 5'd14;
  localparam logic [4:0] EndHour   = 5'd17;
  localparam logic [4:0] EndMinute = 5'd20;
  localparam logic [4:0] PrefixLen = 5'd5;

  // running per-payload state
  logic [4:0]             cnt_q, cnt_d;
  logic [NumPatterns-1:0] alive_q, alive_d;
  logic                   fmt_ok_q, fmt_ok_d;
  logic [13:0]            year_q, year_d;
  logic [6:0]             month_q, month_d;
  logic [6:0]             day_q, day_d;
  logic [6:0]             hour_q, hour_d;
  logic [6:0]             minute_q, minute_d;
  logic [6:0]             second_q, second_d;

  // result side: output register and skid register
  logic                   out_vld_q, out_vld_d;
  logic [OutW-1:0]        out_q, out_d;
  logic                   skid_vld_q, skid_vld_d;
  logic [OutW-1:0]        skid_q, skid_d;

  logic                   in_xfer;
  logic                   res_xfer;
  logic [7:0]             in_byte;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [4:0]             len;
  cmd_kind_e              kind;
  logic                   time_ok;
  logic [OutW-1:0]        res_data;

  assign in_xfer  = s_axis_tvalid_i & s_axis_tready_o;
  assign res_xfer = in_xfer & s_axis_tlast_i;
  assign in_byte  = s_axis_tdata_i;
  assign is_digit = (in_byte >= "0") && (in_byte <= "9");
  assign digit    = in_byte[3:0];

  // match tracking, format check and decimal accumulation for this byte
  always_comb begin
    cnt_d    = (cnt_q < CountMax) ? cnt_q + 5'd1 : cnt_q;
    fmt_ok_d = fmt_ok_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;

    for (int i = 0; i < NumPatterns; i++) begin
      if (cnt_q < pat_len(3'(i))) begin
        alive_d[i] = alive_q[i] && (pat_char(3'(i), cnt_q[3:0]) == in_byte);
      end else begin
        // only the set-time prefix may run past its text
        alive_d[i] = alive_q[i] && (i == TimePattern);
      end
    end

    if (cnt_q < PrefixLen) begin
      if (pat_char(3'(TimePattern), cnt_q[3:0]) != in_byte) fmt_ok_d = 1'b0;
    end else if (cnt_q >= TimeTextLen) begin
      fmt_ok_d = 1'b0;
    end else if (cnt_q == PosDash0 || cnt_q == PosDash1) begin
      if (in_byte != "-") fmt_ok_d = 1'b0;
    end else if (cnt_q == PosComma) begin
      if (in_byte != ",") fmt_ok_d = 1'b0;
    end else if (cnt_q == PosColon0 || cnt_q == PosColon1) begin
      if (in_byte != ":") fmt_ok_d = 1'b0;
    end else if (!is_digit) begin
      fmt_ok_d = 1'b0;
    end else if (cnt_q <= EndYear) begin
      year_d = 14'(year_q * 14'd10 + 14'(digit));
    end else if (cnt_q <= EndMonth) begin
      month_d = 7'(month_q * 7'd10 + 7'(digit));
    end else if (cnt_q <= EndDay) begin
      day_d = 7'(day_q * 7'd10 + 7'(digit));
    end else if (cnt_q <= EndHour) begin
      hour_d = 7'(hour_q * 7'd10 + 7'(digit));
    end else if (cnt_q <= EndMinute) begin
      minute_d = 7'(minute_q * 7'd10 + 7'(digit));
    end else begin
      second_d = 7'(second_q * 7'd10 + 7'(digit));
    end
  end

  // classification on the final byte, first live pattern wins
  always_comb begin
    len  = cnt_d;
    kind = KindUnknown;
    for (int i = NumPatterns - 1; i >= 0; i--) begin
      if (alive_d[i] && ((i == TimePattern) ? (len >= pat_len(3'(i)))
                                            : (len == pat_len(3'(i))))) begin
        kind = cmd_kind_e'(3'(i + 1));
      end
    end
    time_ok = fmt_ok_d && (len == TimeTextLen);
    if (time_ok) begin
      res_data = {3'd0, second_d, minute_d, hour_d, day_d, month_d, year_d,
                  1'b1, kind};
    end else begin
      res_data = {52'd0, 1'b0, kind};
    end
  end

  // per-payload state returns to its start values after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      alive_q  <= '1;
      fmt_ok_q <= 1'b1;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
    end else if (in_xfer) begin
      if (s_axis_tlast_i) begin
        cnt_q    <= '0;
        alive_q  <= '1;
        fmt_ok_q <= 1'b1;
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        hour_q   <= '0;
        minute_q <= '0;
        second_q <= '0;
      end else begin
        cnt_q    <= cnt_d;
        alive_q  <= alive_d;
        fmt_ok_q <= fmt_ok_d;
        year_q   <= year_d;
        month_q  <= month_d;
        day_q    <= day_d;
        hour_q   <= hour_d;
        minute_q <= minute_d;
        second_q <= second_d;
      end
    end
  end

  // output register with skid: a new result lands in the skid register
  // only when the output register is full and stalled
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (!out_vld_q || m_axis_tready_i) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else if (res_xfer) begin
        out_vld_d = 1'b1;
        out_d     = res_data;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (res_xfer) begin
      skid_vld_d = 1'b1;
      skid_d     = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready_o = !skid_vld_q;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

endmodule

FILE: rtl/actp_checker.sv
// ----------------------------------------------------------------------------
// actp_checker
// port-level checks for the ascii command and time parser
// ----------------------------------------------------------------------------
module actp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [actp_pkg::InW-1:0]  s_axis_tdata_i,
  input logic                      s_axis_tlast_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [actp_pkg::OutW-1:0] m_axis_tdata_o
);
  import actp_pkg::*;

  logic last_xfer;
  assign last_xfer = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
    $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // input only backs up behind a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  // after every final byte a result is valid on the next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_xfer |=> m_axis_tvalid_o)
    else $error("final byte produced no result");

  // a parsed time is always a set-time command
  a_time_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3] |-> m_axis_tdata_o[2:0] == KindSetTime)
    else $error("time_ok on a non set-time command");

  // time fields read zero unless the time parsed
  a_time_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[3] |-> m_axis_tdata_o[OutW-1:4] == '0)
    else $error("time fields nonzero without time_ok");

endmodule

bind ascii_command_and_time_parser actp_checker u_actp_checker (.*);
